// ===== rtl/core/text_console_char_writer_defines.svh =====
// Assertion macros used by the console writer back end
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`ifndef SYNTHESIS
// Implication checked every cycle outside reset
`define CTW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition in one cycle implies a condition in the next cycle
`define CTW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CTW_ASSERT(lbl, clk, rst, prop, msg)
`define CTW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/ctw_pkg.sv =====
// Types and constants shared by the text console writer
`timescale 1ns / 1ps
package ctw_pkg;

  // cell address width, wide enough for up to 128 x 64 cells
  localparam int ADDR_MAX_W = 13;

  // request codes
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // character and color constants
  localparam logic [7:0] CH_NEWLINE  = 8'd10;
  localparam logic [7:0] CH_RETURN   = 8'd13;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] RESET_COLOR = 8'h07;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [6:0] read_col;
    logic [4:0] read_row;
  } req_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_pos;
    logic [7:0]  cell_char;
    logic [7:0]  cell_color;
  } res_t;

  // back-end operation classes
  typedef enum logic [1:0] {
    OP_REPORT,
    OP_READ,
    OP_CLEAR
  } op_t;

  // command passed from front to back
  typedef struct packed {
    op_t                   op;
    logic                  wr;
    logic                  scroll;
    logic [7:0]            char_code;
    logic [ADDR_MAX_W-1:0] addr;
    logic [6:0]            cursor_col;
    logic [4:0]            cursor_row;
    logic [10:0]           cursor_pos;
  } cmd_t;

  // queue status seen by the top level
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  typedef enum logic [2:0] {
    BS_INIT,
    BS_IDLE,
    BS_READ,
    BS_MOVE,
    BS_FILL,
    BS_CLEAR
  } back_state_t;

endpackage

// ===== rtl/core/text_console_char_writer.sv =====
// Text console writer: front end, command queue and cell-store back end
// Throughput: one cell-store write per cycle through the single write port; a new
//   transaction is taken each cycle while the two-entry command queue has room and
//   the reset sweep is over.
// Reset: cursor homes, fill_color returns to 7, then busy stays high while the store
//   is swept to spaces in color 7. Results cannot be stalled.
`timescale 1ns / 1ps
module text_console_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ctw_pkg::req_t req,
  output logic          done,
  output ctw_pkg::res_t result,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data
);
  import ctw_pkg::*;

  logic    accept;
  logic    pop;
  logic    init_busy;
  cmd_t    front_cmd;
  cmd_t    head;
  q_stat_t q_stat;

  // transaction acceptance
  assign busy   = init_busy || q_stat.full;
  assign accept = start && !busy;

  ctw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .cmd    (front_cmd)
  );

  ctw_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  ctw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .head       (head),
    .head_valid (q_stat.valid),
    .pop        (pop),
    .init_busy  (init_busy),
    .done       (done),
    .result     (result)
  );

endmodule

// ===== rtl/core/ctw_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module ctw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ctw_front.sv =====
// Front end: cursor tracking and request classification
`timescale 1ns / 1ps
module ctw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  ctw_pkg::req_t req,
  output ctw_pkg::cmd_t cmd
);
  import ctw_pkg::*;

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);

  logic [COL_W-1:0] col, col_next;
  logic [ROW_W-1:0] row, row_next;
  logic             row_inc;
  logic [ADDR_MAX_W-1:0] cur_addr, new_pos, rd_addr;
  logic             rd_in_range;

  // cell address of the cursor and of a read request
  assign cur_addr = ADDR_MAX_W'(row) * ADDR_MAX_W'(COLUMNS) + ADDR_MAX_W'(col);
  assign rd_addr  = ADDR_MAX_W'(req.read_row) * ADDR_MAX_W'(COLUMNS)
                  + ADDR_MAX_W'(req.read_col);
  assign rd_in_range = ({1'b0, req.read_col} < 8'(COLUMNS))
                    && ({2'b0, req.read_row} < 7'(ROWS));
  assign new_pos  = ADDR_MAX_W'(row_next) * ADDR_MAX_W'(COLUMNS) + ADDR_MAX_W'(col_next);

  // classify the request and work out the new cursor
  always_comb begin
    col_next      = col;
    row_next      = row;
    row_inc       = 1'b0;
    cmd.op        = OP_REPORT;
    cmd.wr        = 1'b0;
    cmd.scroll    = 1'b0;
    cmd.char_code = req.char_code;
    cmd.addr      = cur_addr;
    unique case (req.req_type)
      REQ_PUT: begin
        if (req.char_code == CH_NEWLINE) begin
          col_next = '0;
          row_inc  = 1'b1;
        end else if (req.char_code == CH_RETURN) begin
          col_next = '0;
        end else begin
          cmd.wr = 1'b1;
          if (col == COL_W'(COLUMNS - 1)) begin
            col_next = '0;
            row_inc  = 1'b1;
          end else begin
            col_next = col + COL_W'(1);
          end
        end
        if (row_inc) begin
          if (row == ROW_W'(ROWS - 1)) begin
            cmd.scroll = 1'b1;
          end else begin
            row_next = row + ROW_W'(1);
          end
        end
      end
      REQ_CLEAR: begin
        cmd.op   = OP_CLEAR;
        col_next = '0;
        row_next = '0;
      end
      REQ_READ: begin
        if (rd_in_range) begin
          cmd.op   = OP_READ;
          cmd.addr = rd_addr;
        end
      end
      default: begin
        cmd.op = OP_REPORT;
      end
    endcase
    cmd.cursor_col = 7'(col_next);
    cmd.cursor_row = 5'(row_next);
    cmd.cursor_pos = new_pos[10:0];
  end

  // cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

// ===== rtl/core/ctw_cmdq.sv =====
// Two-entry command queue between front and back
`timescale 1ns / 1ps
module ctw_cmdq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ctw_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output ctw_pkg::cmd_t      head,
  output ctw_pkg::q_stat_t   stat
);
  import ctw_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [PTR_W:0]   count;

  assign head       = entries[rptr];
  assign stat.full  = (count == (PTR_W + 1)'(DEPTH));
  assign stat.valid = (count != '0);

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

endmodule

// ===== rtl/core/ctw_back.sv =====
// Back end: cell store, scroll/clear/init sweeps and result register
`timescale 1ns / 1ps
`include "text_console_char_writer_defines.svh"
module ctw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data,
  input  ctw_pkg::cmd_t head,
  input  logic          head_valid,
  output logic          pop,
  output logic          init_busy,
  output logic          done,
  output ctw_pkg::res_t result
);
  import ctw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  back_state_t       state, state_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  logic              mv_pend, mv_pend_next;
  logic [ADDR_W-1:0] mv_addr, mv_addr_next;
  cmd_t              cur, cur_next;
  logic              done_next;
  res_t              res_next;
  logic [7:0]        fill_color;

  logic              char_we, col_we;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        char_wd, col_wd, char_rd, col_rd;

  logic cnt_last, move_last;

  assign cnt_last  = (cnt == ADDR_W'(CELLS - 1));
  assign move_last = (cnt == ADDR_W'(CELLS - COLUMNS - 1));
  assign init_busy = (state == BS_INIT);

  function automatic res_t mk_res(cmd_t c, logic [7:0] ch, logic [7:0] co);
    res_t r;
    r.cursor_col = c.cursor_col;
    r.cursor_row = c.cursor_row;
    r.cursor_pos = c.cursor_pos;
    r.cell_char  = ch;
    r.cell_color = co;
    return r;
  endfunction

  // character and color planes of the cell store
  ctw_ram #(.WIDTH(8), .DEPTH(CELLS)) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (wr_addr),
    .wdata (char_wd),
    .raddr (rd_addr),
    .rdata (char_rd)
  );

  ctw_ram #(.WIDTH(8), .DEPTH(CELLS)) u_color_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (wr_addr),
    .wdata (col_wd),
    .raddr (rd_addr),
    .rdata (col_rd)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BS_INIT: begin
        if (cnt_last) state_next = BS_IDLE;
      end
      BS_IDLE: begin
        if (head_valid) begin
          unique case (head.op)
            OP_READ:  state_next = BS_READ;
            OP_CLEAR: state_next = BS_CLEAR;
            default:  state_next = head.scroll ? BS_MOVE : BS_IDLE;
          endcase
        end
      end
      BS_READ: state_next = BS_IDLE;
      BS_MOVE: begin
        if (move_last) state_next = BS_FILL;
      end
      BS_FILL: begin
        if (!mv_pend && cnt_last) state_next = BS_IDLE;
      end
      BS_CLEAR: begin
        if (cnt_last) state_next = BS_IDLE;
      end
      default: state_next = BS_INIT;
    endcase
  end

  // datapath and store control
  always_comb begin
    pop          = 1'b0;
    char_we      = 1'b0;
    col_we       = 1'b0;
    wr_addr      = mv_addr;
    char_wd      = char_rd;
    col_wd       = col_rd;
    rd_addr      = '0;
    cnt_next     = cnt;
    cur_next     = cur;
    done_next    = 1'b0;
    res_next     = result;
    mv_pend_next = 1'b0;
    mv_addr_next = mv_addr;
    // move write lands in the cycle after its read
    if (mv_pend) begin
      char_we = 1'b1;
      col_we  = 1'b1;
    end
    unique case (state)
      BS_INIT: begin
        char_we  = 1'b1;
        col_we   = 1'b1;
        wr_addr  = cnt;
        char_wd  = CH_SPACE;
        col_wd   = RESET_COLOR;
        cnt_next = cnt_last ? '0 : cnt + ADDR_W'(1);
      end
      BS_IDLE: begin
        if (head_valid) begin
          pop      = 1'b1;
          cur_next = head;
          cnt_next = '0;
          rd_addr  = head.addr[ADDR_W-1:0];
          if (head.op == OP_REPORT) begin
            if (head.wr) begin
              char_we = 1'b1;
              wr_addr = head.addr[ADDR_W-1:0];
              char_wd = head.char_code;
            end
            if (!head.scroll) begin
              done_next = 1'b1;
              res_next  = mk_res(head, 8'h00, 8'h00);
            end
          end
        end
      end
      BS_READ: begin
        done_next = 1'b1;
        res_next  = mk_res(cur, char_rd, col_rd);
      end
      BS_MOVE: begin
        rd_addr      = cnt + ADDR_W'(COLUMNS);
        mv_pend_next = 1'b1;
        mv_addr_next = cnt;
        cnt_next     = cnt + ADDR_W'(1);
      end
      BS_FILL: begin
        if (!mv_pend) begin
          char_we  = 1'b1;
          col_we   = 1'b1;
          wr_addr  = cnt;
          char_wd  = CH_NUL;
          col_wd   = fill_color;
          cnt_next = cnt + ADDR_W'(1);
          if (cnt_last) begin
            done_next = 1'b1;
            res_next  = mk_res(cur, 8'h00, 8'h00);
          end
        end
      end
      BS_CLEAR: begin
        char_we  = 1'b1;
        wr_addr  = cnt;
        char_wd  = CH_SPACE;
        cnt_next = cnt + ADDR_W'(1);
        if (cnt_last) begin
          done_next = 1'b1;
          res_next  = mk_res(cur, 8'h00, 8'h00);
        end
      end
      default: begin
        cnt_next = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BS_INIT;
      cnt        <= '0;
      mv_pend    <= 1'b0;
      done       <= 1'b0;
      fill_color <= RESET_COLOR;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      mv_pend <= mv_pend_next;
      done    <= done_next;
      if (cfg_we) begin
        fill_color <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mv_addr <= mv_addr_next;
    cur     <= cur_next;
    result  <= res_next;
  end

  `CTW_ASSERT(a_wr_in_range, clk, rst, (char_we || col_we) |-> (wr_addr <= ADDR_W'(CELLS - 1)), "store write outside the screen")
  `CTW_ASSERT(a_no_done_init, clk, rst, (state == BS_INIT) |-> !done, "result strobe during init sweep")
  `CTW_ASSERT_NEXT(a_read_done, clk, rst, state == BS_READ, done, "read transaction did not complete")
  `CTW_ASSERT(a_pop_idle, clk, rst, pop |-> (head_valid && state == BS_IDLE), "queue popped outside idle")

endmodule
